[hdl/raycast_wall_texel_mapper_assert.svh]
// assertion macros for the raycast wall texel mapper checks
`ifndef RAYCAST_WALL_TEXEL_MAPPER_ASSERT_SVH
`define RAYCAST_WALL_TEXEL_MAPPER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define RWTM_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rwtm check failed");

// next-cycle implication
`define RWTM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rwtm check failed");

`endif

[hdl/rwtm_pkg.sv]
// shared types and constants of the raycast wall texel mapper
`timescale 1ns / 1ps
package rwtm_pkg;

  localparam int TEX_WIDTH     = 64;
  localparam int TEX_HEIGHT    = 64;
  localparam int NUM_TEX       = 4;
  localparam int TEX_COL_BITS  = $clog2(TEX_WIDTH);
  localparam int TEX_ROW_BITS  = $clog2(TEX_HEIGHT);
  localparam int TEX_SEL_BITS  = $clog2(NUM_TEX);
  localparam int STORE_DEPTH   = NUM_TEX * TEX_WIDTH * TEX_HEIGHT;
  localparam int ADDR_BITS     = TEX_SEL_BITS + TEX_ROW_BITS + TEX_COL_BITS;
  localparam int TEXEL_BITS    = 32;
  localparam int FRAC_BITS     = 22;
  localparam int POS_INT_BITS  = FRAC_BITS - 14;

  // row divider: 16-bit magnitude scaled by the texture height
  localparam int MAG_BITS      = 16;
  localparam int DIV_W         = MAG_BITS + TEX_ROW_BITS;
  localparam int DIV_PER_STAGE = 2;
  localparam int DIV_STAGES    = (DIV_W + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

  // accept edge to result cycle: front two stages, divider, texel read
  localparam int LATENCY       = DIV_STAGES + 3;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  typedef enum logic [1:0] {
    TEX_NORTH = 2'd0,
    TEX_SOUTH = 2'd1,
    TEX_EAST  = 2'd2,
    TEX_WEST  = 2'd3
  } tex_e;

  // everything that rides alongside the row division
  typedef struct packed {
    logic                     valid;
    logic                     draw;
    logic                     fault;
    tex_e                     tex;
    logic [TEX_COL_BITS-1:0]  col;
    logic                     neg;
    logic [11:0]              column;
    logic [11:0]              row;
    logic [ADDR_BITS-1:0]     load_addr;
    logic [TEXEL_BITS-1:0]    load_color;
  } side_t;

  // partial state of the restoring division
  typedef struct packed {
    logic [MAG_BITS-1:0]      rem;
    logic [DIV_W-1:0]         dividend;
    logic [TEX_ROW_BITS-1:0]  quo;
    logic [15:0]              divisor;
  } div_t;

endpackage

[hdl/rwtm_ram.sv]
// generic single-write, single-read memory with registered read data
`timescale 1ns / 1ps
module rwtm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/rwtm_front.sv]
// front stages: texture pick, hit product, row numerator, texture column
`timescale 1ns / 1ps
module rwtm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [12:0]         screen_height_i,
  input  logic                mode_i,
  input  logic signed [15:0]  ray_dir_x_i,
  input  logic signed [15:0]  ray_dir_y_i,
  input  logic                hit_side_i,
  input  logic [15:0]         wall_distance_i,
  input  logic [15:0]         player_x_i,
  input  logic [15:0]         player_y_i,
  input  logic [15:0]         line_height_i,
  input  logic [11:0]         pixel_y_i,
  input  logic [11:0]         column_x_i,
  input  logic [13:0]         load_address_i,
  input  logic [31:0]         load_color_i,
  output rwtm_pkg::side_t     side_o,
  output rwtm_pkg::div_t      div_o
);

  // stage a registers
  rwtm_pkg::side_t                     a_side_d, a_side_q;
  logic [rwtm_pkg::FRAC_BITS-1:0]      a_prod_d, a_prod_q;
  logic [rwtm_pkg::POS_INT_BITS-1:0]   a_base_d, a_base_q;
  logic                                a_mirror_d, a_mirror_q;
  logic [rwtm_pkg::MAG_BITS-1:0]       a_mag_d, a_mag_q;
  logic [15:0]                         a_lh_d, a_lh_q;

  // stage b registers
  rwtm_pkg::side_t                     b_side_d, b_side_q;
  rwtm_pkg::div_t                      b_div_d, b_div_q;

  logic signed [32:0]                  prod_full;
  logic signed [17:0]                  row_sum;
  logic [17:0]                         row_abs;
  logic signed [15:0]                  dir_sel;
  logic [15:0]                         base_sel;
  logic                                dx_zero, dy_zero, dx_pos, dy_neg;
  logic [rwtm_pkg::FRAC_BITS-1:0]      frac;
  logic [rwtm_pkg::TEX_COL_BITS-1:0]   col_raw;

  assign dx_zero = (ray_dir_x_i == 16'sd0);
  assign dy_zero = (ray_dir_y_i == 16'sd0);
  assign dx_pos  = !ray_dir_x_i[15] && !dx_zero;
  assign dy_neg  = ray_dir_y_i[15];

  // stage a: texture pick, mirror flag, hit product, row numerator
  always_comb begin
    dir_sel   = hit_side_i ? ray_dir_x_i : ray_dir_y_i;
    base_sel  = hit_side_i ? player_x_i : player_y_i;
    prod_full = $signed({1'b0, wall_distance_i}) * dir_sel;
    a_lh_d    = (line_height_i == 16'd0) ? 16'd1 : line_height_i;
    row_sum   = $signed({6'b0, pixel_y_i}) - $signed({6'b0, screen_height_i[12:1]})
              + $signed({3'b0, a_lh_d[15:1]});
    row_abs   = row_sum[17] ? (18'd0 - row_sum) : row_sum;

    a_side_d.valid      = valid_i;
    a_side_d.draw       = (mode_i == rwtm_pkg::MODE_DRAW);
    a_side_d.fault      = dx_zero && dy_zero;
    if ((hit_side_i && !dy_zero) || dx_zero) begin
      a_side_d.tex = dy_neg ? rwtm_pkg::TEX_NORTH : rwtm_pkg::TEX_SOUTH;
    end else begin
      a_side_d.tex = dx_pos ? rwtm_pkg::TEX_EAST : rwtm_pkg::TEX_WEST;
    end
    a_side_d.col        = '0;
    a_side_d.neg        = row_sum[17];
    a_side_d.column     = column_x_i;
    a_side_d.row        = pixel_y_i;
    a_side_d.load_addr  = load_address_i[rwtm_pkg::ADDR_BITS-1:0];
    a_side_d.load_color = load_color_i;

    a_prod_d   = prod_full[rwtm_pkg::FRAC_BITS-1:0];
    a_base_d   = base_sel[rwtm_pkg::POS_INT_BITS-1:0];
    a_mirror_d = hit_side_i ? dy_neg : dx_pos;
    a_mag_d    = row_abs[rwtm_pkg::MAG_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_side_q <= '0;
    end else begin
      a_side_q <= a_side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_prod_q   <= a_prod_d;
    a_base_q   <= a_base_d;
    a_mirror_q <= a_mirror_d;
    a_mag_q    <= a_mag_d;
    a_lh_q     <= a_lh_d;
  end

  // stage b: hit fraction, texture column with mirroring, divider setup
  always_comb begin
    frac    = {a_base_q, 14'd0} + a_prod_q;
    col_raw = frac[rwtm_pkg::FRAC_BITS-1 -: rwtm_pkg::TEX_COL_BITS];

    b_side_d     = a_side_q;
    b_side_d.col = a_mirror_q ? ~col_raw : col_raw;

    b_div_d.rem      = '0;
    b_div_d.dividend = {a_mag_q, {rwtm_pkg::TEX_ROW_BITS{1'b0}}};
    b_div_d.quo      = '0;
    b_div_d.divisor  = a_lh_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_side_q <= '0;
    end else begin
      b_side_q <= b_side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_div_q <= b_div_d;
  end

  assign side_o = b_side_q;
  assign div_o  = b_div_q;

endmodule

[hdl/rwtm_row_div.sv]
// pipelined restoring divider for the texture row, two quotient bits a stage
`timescale 1ns / 1ps
module rwtm_row_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rwtm_pkg::side_t  side_i,
  input  rwtm_pkg::div_t   div_i,
  output rwtm_pkg::side_t  side_o,
  output rwtm_pkg::div_t   div_o
);

  rwtm_pkg::side_t side_q [rwtm_pkg::DIV_STAGES+1];
  rwtm_pkg::div_t  div_q  [rwtm_pkg::DIV_STAGES+1];

  assign side_q[0] = side_i;
  assign div_q[0]  = div_i;

  for (genvar s = 0; s < rwtm_pkg::DIV_STAGES; s++) begin : g_stage
    rwtm_pkg::div_t step_d;

    // two compare-subtract steps
    always_comb begin
      logic [rwtm_pkg::MAG_BITS:0] trial;
      step_d = div_q[s];
      for (int k = 0; k < rwtm_pkg::DIV_PER_STAGE; k++) begin
        trial           = {step_d.rem, step_d.dividend[rwtm_pkg::DIV_W-1]};
        step_d.dividend = {step_d.dividend[rwtm_pkg::DIV_W-2:0], 1'b0};
        if (trial >= {1'b0, step_d.divisor}) begin
          trial      = trial - {1'b0, step_d.divisor};
          step_d.quo = {step_d.quo[rwtm_pkg::TEX_ROW_BITS-2:0], 1'b1};
        end else begin
          step_d.quo = {step_d.quo[rwtm_pkg::TEX_ROW_BITS-2:0], 1'b0};
        end
        step_d.rem = trial[rwtm_pkg::MAG_BITS-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[s+1] <= '0;
      end else begin
        side_q[s+1] <= side_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      div_q[s+1] <= step_d;
    end
  end

  assign side_o = side_q[rwtm_pkg::DIV_STAGES];
  assign div_o  = div_q[rwtm_pkg::DIV_STAGES];

endmodule

[hdl/raycast_wall_texel_mapper.sv]
// Raycast wall texel mapper: one beat per clock, loads and draws in any mix.
// busy is never raised, so a new beat is taken in every cycle. A draw beat
// shows its result on out_valid_o after passing the pipeline stages in order:
// the two front stages, the 11-stage row divider that yields two quotient
// bits per stage, and the registered texel read. A load beat travels the
// same pipe and writes the texel store at the stage where draws read it, so
// texels are seen in beat order; a load gives no result. Results cannot be
// held off by the receiver. No clearing pass is run after reset.
`timescale 1ns / 1ps
module raycast_wall_texel_mapper (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [12:0]  cfg_wdata_i,
  input  logic         start,
  output logic         busy,
  input  logic         mode_i,
  input  logic [15:0]  ray_dir_x_i,
  input  logic [15:0]  ray_dir_y_i,
  input  logic         hit_side_i,
  input  logic [15:0]  wall_distance_i,
  input  logic [15:0]  player_x_i,
  input  logic [15:0]  player_y_i,
  input  logic [15:0]  line_height_i,
  input  logic [11:0]  pixel_y_i,
  input  logic [11:0]  column_x_i,
  input  logic [13:0]  load_address_i,
  input  logic [31:0]  load_color_i,
  output logic         out_valid_o,
  output logic [11:0]  out_column_o,
  output logic [11:0]  out_row_o,
  output logic [31:0]  pixel_color_o,
  output logic         direction_fault_o
);

  logic [12:0]                        screen_height_q;
  rwtm_pkg::side_t                    front_side, div_side;
  rwtm_pkg::div_t                     front_div, div_res;
  logic [rwtm_pkg::TEX_ROW_BITS-1:0]  row_neg, row_fix;
  logic [rwtm_pkg::ADDR_BITS-1:0]     rd_addr;
  logic                               ram_we, ram_re;
  logic [rwtm_pkg::TEXEL_BITS-1:0]    ram_rdata;
  logic                               res_valid_q;
  logic                               res_fault_q;
  logic [11:0]                        res_column_q, res_row_q;

  assign busy = 1'b0;

  // screen height register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_height_q <= 13'd480;
    end else if (cfg_we_i) begin
      screen_height_q <= cfg_wdata_i;
    end
  end

  rwtm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (start && !busy),
    .screen_height_i (screen_height_q),
    .mode_i          (mode_i),
    .ray_dir_x_i     (ray_dir_x_i),
    .ray_dir_y_i     (ray_dir_y_i),
    .hit_side_i      (hit_side_i),
    .wall_distance_i (wall_distance_i),
    .player_x_i      (player_x_i),
    .player_y_i      (player_y_i),
    .line_height_i   (line_height_i),
    .pixel_y_i       (pixel_y_i),
    .column_x_i      (column_x_i),
    .load_address_i  (load_address_i),
    .load_color_i    (load_color_i),
    .side_o          (front_side),
    .div_o           (front_div)
  );

  rwtm_row_div u_row_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .side_i (front_side),
    .div_i  (front_div),
    .side_o (div_side),
    .div_o  (div_res)
  );

  // signed row wrap and texel address
  assign row_neg = {rwtm_pkg::TEX_ROW_BITS{1'b0}} - div_res.quo;
  assign row_fix = div_side.neg ? row_neg : div_res.quo;
  assign rd_addr = {div_side.tex, row_fix, div_side.col};
  assign ram_we  = div_side.valid && !div_side.draw;
  assign ram_re  = div_side.valid && div_side.draw;

  rwtm_ram #(
    .WIDTH (rwtm_pkg::TEXEL_BITS),
    .DEPTH (rwtm_pkg::STORE_DEPTH)
  ) u_texel_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (div_side.load_addr),
    .wdata_i (div_side.load_color),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // result stage alongside the texel read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ram_re;
    end
  end

  always_ff @(posedge clk_i) begin
    res_fault_q  <= div_side.fault;
    res_column_q <= div_side.column;
    res_row_q    <= div_side.row;
  end

  assign out_valid_o       = res_valid_q;
  assign out_column_o      = res_column_q;
  assign out_row_o         = res_row_q;
  assign direction_fault_o = res_fault_q;
  assign pixel_color_o     = res_fault_q ? '0 : ram_rdata;

endmodule

[hdl/rwtm_checker.sv]
// port-level checks of the raycast wall texel mapper, bound to the top level
`timescale 1ns / 1ps
`include "raycast_wall_texel_mapper_assert.svh"
module rwtm_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         start,
  input logic         busy,
  input logic         mode_i,
  input logic [15:0]  ray_dir_x_i,
  input logic [15:0]  ray_dir_y_i,
  input logic [11:0]  pixel_y_i,
  input logic [11:0]  column_x_i,
  input logic         out_valid_o,
  input logic [11:0]  out_column_o,
  input logic [11:0]  out_row_o,
  input logic [31:0]  pixel_color_o,
  input logic         direction_fault_o
);

  // a fault result carries a zero color
  `RWTM_ASSERT(a_fault_color, out_valid_o && direction_fault_o, pixel_color_o == 32'd0)

  // every result comes from a draw beat taken the pipeline depth earlier
  `RWTM_ASSERT(a_result_origin, out_valid_o, $past(start && !busy && mode_i, rwtm_pkg::LATENCY))

  // row and column pass through with the pipeline delay
  `RWTM_ASSERT(a_pass_through, out_valid_o, (out_row_o == $past(pixel_y_i, rwtm_pkg::LATENCY)) && (out_column_o == $past(column_x_i, rwtm_pkg::LATENCY)))

  // fault flag matches a zero direction at entry
  `RWTM_ASSERT(a_fault_source, out_valid_o, direction_fault_o == $past((ray_dir_x_i == 16'd0) && (ray_dir_y_i == 16'd0), rwtm_pkg::LATENCY))

  // the block never holds off a beat
  `RWTM_ASSERT_NEXT(a_never_busy, 1'b1, !busy)

endmodule

bind raycast_wall_texel_mapper rwtm_checker u_rwtm_checker (.*);
